@@ sv/gic_pkg.sv @@
`timescale 1ns / 1ps
package gic_pkg;

    localparam int DIGITAL_W = 14;
    localparam int LEVEL_W   = 24;
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 3;
    localparam int NUM_REGS  = 8;
    localparam int NUM_AXES  = 6;
    localparam int MAG_W     = 15;
    localparam int WIDE_W    = 24;
    localparam int DIV_STEPS = 15;

    localparam logic [CFG_IDX_W-1:0] REG_LEFT_DEAD   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RIGHT_DEAD  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LEFT_FULL   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_RIGHT_FULL  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_TRIG_DEAD   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_TRIG_FULL   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_STICK_PRESS = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_TRIG_PRESS  = 3'd7;

    // Register 0 sits in the lowest slice.
    localparam logic [NUM_REGS-1:0][CFG_W-1:0] CFG_RESET = {
        16'd32768, 16'd32768, 16'd29491, 16'd3277,
        16'd29491, 16'd29491, 16'd6554,  16'd6554
    };

    localparam logic [2:0] AXIS_LX   = 3'd0;
    localparam logic [2:0] AXIS_LY   = 3'd1;
    localparam logic [2:0] AXIS_RX   = 3'd2;
    localparam logic [2:0] AXIS_RY   = 3'd3;
    localparam logic [2:0] AXIS_LT   = 3'd4;
    localparam logic [2:0] AXIS_RT   = 3'd5;
    localparam logic [2:0] AXIS_LAST = AXIS_RT;

    localparam logic [MAG_W-1:0] MAG_MAX = 15'h7FFF;

    typedef struct packed {
        logic                 pad_present;
        logic [DIGITAL_W-1:0] digital_buttons;
        logic signed [15:0]   raw_left_x;
        logic signed [15:0]   raw_left_y;
        logic signed [15:0]   raw_right_x;
        logic signed [15:0]   raw_right_y;
        logic [7:0]           raw_left_trigger;
        logic [7:0]           raw_right_trigger;
    } t_poll;

    typedef struct packed {
        logic               was_connected;
        logic [LEVEL_W-1:0] button_levels;
        logic [LEVEL_W-1:0] button_rises;
        logic [LEVEL_W-1:0] button_falls;
        logic               any_activity;
        logic signed [15:0] left_stick_x;
        logic signed [15:0] left_stick_y;
        logic signed [15:0] right_stick_x;
        logic signed [15:0] right_stick_y;
        logic [MAG_W-1:0]   left_pull;
        logic [MAG_W-1:0]   right_pull;
    } t_result;

    typedef struct packed {
        logic       capture;
        logic       setup;
        logic       div_step;
        logic       write_axis;
        logic       emit;
        logic [2:0] axis_sel;
    } t_cmd;

    typedef struct packed {
        logic present;
        logic need_div;
        logic out_free;
    } t_sts;

endpackage

@@ sv/gic_stream_if.sv @@
`timescale 1ns / 1ps
interface gic_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

@@ sv/gic_ctrl.sv @@
`timescale 1ns / 1ps
module gic_ctrl import gic_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_SETUP = 5'b00010,
        S_DIV   = 5'b00100,
        S_WRITE = 5'b01000,
        S_DONE  = 5'b10000
    } t_state;

    localparam logic [3:0] DIV_LAST = 4'(DIV_STEPS - 1);

    t_state     r_state, n_state;
    logic [2:0] r_k, n_k;
    logic [3:0] r_cnt, n_cnt;

    always_comb begin
        n_state    = r_state;
        n_k        = r_k;
        n_cnt      = r_cnt;
        o_cmd      = '0;
        o_cmd.axis_sel = r_k;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = i_rst_n;
                if (i_rst_n && i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_k     = AXIS_LX;
                    n_state = S_SETUP;
                end
            end
            S_SETUP: begin
                if (!i_sts.present) begin
                    n_state = S_DONE;
                end else begin
                    o_cmd.setup = 1'b1;
                    n_cnt   = '0;
                    n_state = i_sts.need_div ? S_DIV : S_WRITE;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                n_cnt = r_cnt + 4'd1;
                if (r_cnt == DIV_LAST) begin
                    n_state = S_WRITE;
                end
            end
            S_WRITE: begin
                o_cmd.write_axis = 1'b1;
                if (r_k == AXIS_LAST) begin
                    n_state = S_DONE;
                end else begin
                    n_k     = r_k + 3'd1;
                    n_state = S_SETUP;
                end
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_k     <= '0;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_k     <= n_k;
            r_cnt   <= n_cnt;
        end
    end

`ifndef NO_ASSERTIONS
    a_axis_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_k <= AXIS_LAST)
        else $error("axis index out of range");

    a_div_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_DIV |-> r_cnt <= DIV_LAST)
        else $error("divider ran past its last step");

    a_setup_follows_capture: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.capture |=> r_state == S_SETUP && r_k == AXIS_LX)
        else $error("capture did not start axis sequence");
`endif

endmodule

@@ sv/gic_datapath.sv @@
`timescale 1ns / 1ps
module gic_datapath import gic_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_cmd                 i_cmd,
    output t_sts                 o_sts,
    input  t_poll                i_poll,
    input  logic                 i_out_ready,
    output logic                 o_out_valid,
    output t_result              o_result,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data
);

    function automatic logic [WIDE_W-1:0] times255(input logic [CFG_W-1:0] x);
        return {x, 8'd0} - {8'd0, x};
    endfunction

    function automatic logic [3:0] dir_bits(input logic [15:0] x, input logic [15:0] y,
                                            input logic [CFG_W-1:0] lvl);
        logic signed [17:0] xs;
        logic signed [17:0] ys;
        logic signed [17:0] pos;
        logic signed [17:0] neg;
        xs  = {{2{x[15]}}, x};
        ys  = {{2{y[15]}}, y};
        pos = {2'b00, lvl};
        neg = -pos;
        return {xs >= pos, xs <= neg, ys <= neg, ys >= pos};
    endfunction

    logic [CFG_W-1:0]     r_cfg [NUM_REGS];
    t_poll                r_poll;
    logic [LEVEL_W-1:0]   r_levels;
    logic [LEVEL_W-1:0]   r_held_btn;
    logic signed [15:0]   r_held_axes [NUM_AXES];
    logic [WIDE_W-1:0]    r_rem;
    logic [WIDE_W-1:0]    r_den;
    logic [MAG_W-1:0]     r_mag;
    logic                 r_neg;
    logic                 r_out_valid;
    t_result              r_out;

    logic [LEVEL_W-1:0]   cap_levels;
    logic [15:0]          sel_raw;
    logic [7:0]           sel_trig;
    logic                 sel_is_trig;
    logic [CFG_W-1:0]     sel_dead;
    logic [CFG_W-1:0]     sel_full;
    logic [16:0]          stick_abs;
    logic [WIDE_W-1:0]    m_val;
    logic [WIDE_W-1:0]    dead_val;
    logic [WIDE_W-1:0]    full_val;
    logic                 in_zero;
    logic                 in_neg;
    logic [MAG_W-1:0]     setup_mag;
    logic                 need_div;
    logic [WIDE_W:0]      step_shift;
    logic [WIDE_W:0]      step_diff;
    logic                 step_bit;
    logic [15:0]          axis_val;
    logic [LEVEL_W-1:0]   new_levels;
    logic [LEVEL_W-1:0]   new_rises;
    logic [LEVEL_W-1:0]   new_falls;
    logic                 axes_active;
    logic                 out_free;

    always_comb begin
        cap_levels = {
            {1'b0, i_poll.raw_right_trigger, 15'd0} >= times255(r_cfg[REG_TRIG_PRESS]),
            {1'b0, i_poll.raw_left_trigger, 15'd0} >= times255(r_cfg[REG_TRIG_PRESS]),
            dir_bits(i_poll.raw_right_x, i_poll.raw_right_y, r_cfg[REG_STICK_PRESS]),
            dir_bits(i_poll.raw_left_x, i_poll.raw_left_y, r_cfg[REG_STICK_PRESS]),
            i_poll.digital_buttons
        };
    end

    always_comb begin
        sel_raw     = r_poll.raw_left_x;
        sel_trig    = '0;
        sel_is_trig = 1'b0;
        sel_dead    = r_cfg[REG_LEFT_DEAD];
        sel_full    = r_cfg[REG_LEFT_FULL];
        case (i_cmd.axis_sel)
            AXIS_LY: begin
                sel_raw = r_poll.raw_left_y;
            end
            AXIS_RX: begin
                sel_raw  = r_poll.raw_right_x;
                sel_dead = r_cfg[REG_RIGHT_DEAD];
                sel_full = r_cfg[REG_RIGHT_FULL];
            end
            AXIS_RY: begin
                sel_raw  = r_poll.raw_right_y;
                sel_dead = r_cfg[REG_RIGHT_DEAD];
                sel_full = r_cfg[REG_RIGHT_FULL];
            end
            AXIS_LT: begin
                sel_trig    = r_poll.raw_left_trigger;
                sel_is_trig = 1'b1;
                sel_dead    = r_cfg[REG_TRIG_DEAD];
                sel_full    = r_cfg[REG_TRIG_FULL];
            end
            AXIS_RT: begin
                sel_trig    = r_poll.raw_right_trigger;
                sel_is_trig = 1'b1;
                sel_dead    = r_cfg[REG_TRIG_DEAD];
                sel_full    = r_cfg[REG_TRIG_FULL];
            end
            default: begin
                sel_raw = r_poll.raw_left_x;
            end
        endcase

        stick_abs = sel_raw[15] ? (~{1'b1, sel_raw}) + 17'd1 : {1'b0, sel_raw};
        in_zero   = sel_is_trig ? (sel_trig == 8'd0) : (sel_raw == 16'd0);
        in_neg    = !sel_is_trig && sel_raw[15];
        m_val     = sel_is_trig ? {1'b0, sel_trig, 15'd0} : {7'd0, stick_abs};
        dead_val  = sel_is_trig ? times255(sel_dead) : {8'd0, sel_dead};
        full_val  = sel_is_trig ? times255(sel_full) : {8'd0, sel_full};

        need_div  = 1'b0;
        setup_mag = '0;
        if (in_zero) begin
            setup_mag = '0;
        end else if (full_val <= dead_val) begin
            setup_mag = (m_val < dead_val) ? '0 : MAG_MAX;
        end else if (m_val <= dead_val) begin
            setup_mag = '0;
        end else if (m_val >= full_val) begin
            setup_mag = MAG_MAX;
        end else begin
            need_div = 1'b1;
        end
    end

    assign step_shift = {r_rem, 1'b0};
    assign step_diff  = step_shift - {1'b0, r_den};
    assign step_bit   = step_shift >= {1'b0, r_den};
    assign axis_val   = r_neg ? (~{1'b0, r_mag}) + 16'd1 : {1'b0, r_mag};

    always_comb begin
        axes_active = 1'b0;
        for (int i = 0; i < NUM_AXES; i++) begin
            if (r_held_axes[i] != 16'sd0) begin
                axes_active = 1'b1;
            end
        end
    end

    assign new_levels = r_poll.pad_present ? r_levels : r_held_btn;
    assign new_rises  = r_poll.pad_present ? (r_levels & ~r_held_btn) : '0;
    assign new_falls  = r_poll.pad_present ? (~r_levels & r_held_btn) : '0;
    assign out_free   = !r_out_valid || i_out_ready;

    assign o_sts.present  = r_poll.pad_present;
    assign o_sts.need_div = need_div;
    assign o_sts.out_free = out_free;
    assign o_out_valid    = r_out_valid;
    assign o_result       = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_REGS; i++) begin
                r_cfg[i] <= CFG_RESET[i];
            end
        end else if (i_cfg_we) begin
            r_cfg[i_cfg_idx] <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_poll   <= i_poll;
            r_levels <= cap_levels;
        end
        if (i_cmd.setup) begin
            r_rem <= m_val - dead_val;
            r_den <= full_val - dead_val;
            r_mag <= setup_mag;
            r_neg <= in_neg;
        end else if (i_cmd.div_step) begin
            r_rem <= step_bit ? step_diff[WIDE_W-1:0] : step_shift[WIDE_W-1:0];
            r_mag <= {r_mag[MAG_W-2:0], step_bit};
        end
        if (i_cmd.emit) begin
            r_out.was_connected <= r_poll.pad_present;
            r_out.button_levels <= new_levels;
            r_out.button_rises  <= new_rises;
            r_out.button_falls  <= new_falls;
            r_out.any_activity  <= (|new_levels) || axes_active;
            r_out.left_stick_x  <= r_held_axes[AXIS_LX];
            r_out.left_stick_y  <= r_held_axes[AXIS_LY];
            r_out.right_stick_x <= r_held_axes[AXIS_RX];
            r_out.right_stick_y <= r_held_axes[AXIS_RY];
            r_out.left_pull     <= r_held_axes[AXIS_LT][MAG_W-1:0];
            r_out.right_pull    <= r_held_axes[AXIS_RT][MAG_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held_btn  <= '0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < NUM_AXES; i++) begin
                r_held_axes[i] <= '0;
            end
        end else begin
            if (i_cmd.write_axis) begin
                r_held_axes[i_cmd.axis_sel] <= axis_val;
            end
            if (i_cmd.emit) begin
                r_held_btn  <= new_levels;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

`ifndef NO_ASSERTIONS
    a_emit_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |-> !r_out_valid || i_out_ready)
        else $error("result overwritten before it was taken");

    a_rise_fall_disjoint: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out.button_rises & r_out.button_falls) == '0)
        else $error("button both rose and fell");

    a_absent_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit && !r_poll.pad_present |=> $stable(r_held_btn))
        else $error("held buttons changed on absent poll");
`endif

endmodule

@@ sv/gamepad_input_conditioner.sv @@
`timescale 1ns / 1ps
// Conditions one gamepad poll per item: axial dead zone on the four stick axes and two
// triggers, ten analog buttons from press thresholds, and rise/fall masks against the
// previous poll. A connected poll is handled as a capture, then for each of the six axes a
// setup step, the shared restoring divider (one quotient bit per cycle) and a write step,
// then the result is loaded into the output register as soon as that register is free; an
// axis whose result is settled by the zone limits skips the divider. A poll with the pad
// absent skips the axes and repeats the held state. A new item is taken once the previous
// one has been moved into the output register, even if that result has not yet been taken.
// Configuration registers must be written only while the block is idle.
module gamepad_input_conditioner import gic_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    gic_stream_if.sink           i_poll,
    gic_stream_if.source         o_result,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data
);

    t_cmd    cmd;
    t_sts    sts;
    logic    in_ready;
    logic    out_valid;
    t_result result;

    gic_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_poll.valid),
        .o_in_ready (in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    gic_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_poll      (i_poll.data),
        .i_out_ready (o_result.ready),
        .o_out_valid (out_valid),
        .o_result    (result),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data)
    );

    assign i_poll.ready   = in_ready;
    assign o_result.valid = out_valid;
    assign o_result.data  = result;

endmodule
